@@ rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: operation and status codes,
// default geometry and the usable region code.
// No dependencies.
`default_nettype none

package bpa_pkg;

	localparam int PAGE_COUNT_DEF = 32768;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int WORD_BITS      = 32;

	localparam logic [7:0] REGION_USABLE = 8'd1;

	typedef enum logic [1:0] {
		OP_ALLOC      = 2'd0,
		OP_FREE       = 2'd1,
		OP_FREE_RANGE = 2'd2,
		OP_RESERVE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ rtl/bpa_if.sv @@
// Valid/ready channels of the bitmap page allocator: request and response.
// Depends on bpa_pkg.
`default_nettype none

interface bpa_req_if;
	logic         valid;
	logic         ready;
	bpa_pkg::op_t op;
	logic [31:0]  address;
	logic [31:0]  length;
	logic [7:0]   region_type;

	modport source (output valid, op, address, length, region_type, input ready);
	modport sink   (input valid, op, address, length, region_type, output ready);
endinterface

interface bpa_rsp_if;
	logic             valid;
	logic             ready;
	logic [31:0]      page_address;
	bpa_pkg::status_t status;

	modport source (output valid, page_address, status, input ready);
	modport sink   (input valid, page_address, status, output ready);
endinterface

`default_nettype wire

@@ rtl/bitmap_page_allocator.sv @@
// Bitmap page allocator: used-bit memory, operation sequencer, response register.
// Depends on bpa_pkg and the channel interfaces in bpa_if.sv.
//
// Usage:
//  req carries one request (op, address, length, region_type); rsp returns one
//  response (page_address, status) per request, in order. One request is in
//  work at a time; req.ready is high only while the block is idle.
//  The bitmap lives in one memory of ceil(PAGE_COUNT/32) words with a registered
//  read, swept one word per cycle by a read/modify/write pipeline.
//  Allocate scans words from the lowest word that may hold a free page (a hint
//  register skips words known to be full), and answers without a scan when the
//  hint shows no free page. Free, free-range and reserve-below touch only the
//  words in their range, and answer without a memory pass when nothing changes.
//  After reset a clearing pass writes every word to all ones (every page used);
//  req.ready stays low during this pass.
//  The response register holds a finished response while rsp.ready is low;
//  the block still takes the next request and finishes it, then holds it
//  until the register frees. PAGE_BYTES must be a power of two.
`default_nettype none

module bitmap_page_allocator #(
	parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp
);
	import bpa_pkg::*;

	localparam int NW  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
	localparam int WCW = $clog2(NW + 1);
	localparam int PCW = $clog2(PAGE_COUNT + 1);
	localparam int SH  = $clog2(PAGE_BYTES);

	localparam logic [WCW-1:0] NW_C   = WCW'(NW);
	localparam logic [WCW-1:0] LAST_W = WCW'(NW - 1);
	localparam logic [32:0]    PC_C   = 33'(PAGE_COUNT);

	typedef enum logic [1:0] {S_INIT, S_IDLE, S_RUN, S_DONE} state_t;

	logic [31:0] mem [NW];
	logic [31:0] rdata_s1;

	state_t         state_q;
	logic [WCW-1:0] rd_ptr_q;
	logic [WCW-1:0] hint_q;
	logic           alloc_q;
	logic           set_q;
	logic [PCW-1:0] lo_q;
	logic [PCW-1:0] last_q;
	logic           v_s1;
	logic [WCW-1:0] w_s1;
	logic [31:0]    res_page_q;
	status_t        res_status_q;
	logic           rsp_valid_q;
	logic [31:0]    rsp_page_q;
	status_t        rsp_status_q;

	// request decode
	logic [32:0]    base_c, sum_c, lo_raw, hi_raw, hi_clamp, last_c;
	logic           over_c, empty_c, act_c;
	logic [WCW-1:0] lo_w_c;
	status_t        range_status_c;

	always_comb begin
		base_c = {1'b0, req.address} >> SH;
		sum_c  = ({1'b0, req.address} + {1'b0, req.length}) >> SH;
		unique case (req.op)
			OP_ALLOC: begin
				lo_raw = '0;
				hi_raw = '0;
			end
			OP_FREE: begin
				lo_raw = base_c;
				hi_raw = base_c + 33'd1;
			end
			OP_FREE_RANGE: begin
				lo_raw = base_c;
				hi_raw = sum_c;
			end
			OP_RESERVE: begin
				lo_raw = '0;
				hi_raw = base_c;
			end
			default: begin
				lo_raw = '0;
				hi_raw = '0;
			end
		endcase
		over_c   = hi_raw > PC_C;
		hi_clamp = over_c ? PC_C : hi_raw;
		empty_c  = lo_raw >= hi_clamp;
		last_c   = hi_clamp - 33'd1;
		lo_w_c   = WCW'(lo_raw >> 5);
		act_c    = (req.op != OP_ALLOC)
			&& !(req.op == OP_FREE_RANGE && req.region_type != REGION_USABLE);
		if (!act_c) begin
			range_status_c = STAT_DONE;
		end else if (over_c) begin
			range_status_c = STAT_RANGE;
		end else begin
			range_status_c = STAT_DONE;
		end
	end

	// read issue
	logic           rd_en_c;
	logic [WCW-1:0] last_w_c;

	assign last_w_c = WCW'(last_q >> 5);

	always_comb begin
		rd_en_c = 1'b0;
		if (state_q == S_RUN) begin
			rd_en_c = alloc_q ? (rd_ptr_q < NW_C) : (rd_ptr_q <= last_w_c);
		end
	end

	// modify stage
	logic           has_zero_c;
	logic [4:0]     fz_c;
	logic [4:0]     lo_b_c, hi_b_c;
	logic [31:0]    mask_c;
	logic           done_c;
	logic           we_c;
	logic [WAW-1:0] wa_c;
	logic [31:0]    wd_c;

	always_comb begin
		has_zero_c = rdata_s1 != '1;
		fz_c = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (!rdata_s1[b]) begin
				fz_c = 5'(b);
			end
		end
		lo_b_c = (w_s1 == WCW'(lo_q >> 5)) ? lo_q[4:0] : 5'd0;
		hi_b_c = (w_s1 == last_w_c) ? last_q[4:0] : 5'd31;
		mask_c = ({32{1'b1}} << lo_b_c) & ({32{1'b1}} >> (5'd31 - hi_b_c));

		done_c = 1'b0;
		we_c   = 1'b0;
		wa_c   = w_s1[WAW-1:0];
		wd_c   = rdata_s1;
		unique case (state_q)
			S_INIT: begin
				we_c = 1'b1;
				wa_c = rd_ptr_q[WAW-1:0];
				wd_c = '1;
			end
			S_RUN: begin
				if (v_s1) begin
					if (alloc_q) begin
						done_c = has_zero_c || (w_s1 == LAST_W);
						we_c   = has_zero_c;
						wd_c   = rdata_s1 | (32'd1 << fz_c);
					end else begin
						done_c = w_s1 == last_w_c;
						we_c   = 1'b1;
						wd_c   = set_q ? (rdata_s1 | mask_c) : (rdata_s1 & ~mask_c);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		if (rd_en_c) begin
			rdata_s1 <= mem[rd_ptr_q[WAW-1:0]];
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.page_address = rsp_page_q;
	assign rsp.status       = rsp_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			rd_ptr_q     <= '0;
			hint_q       <= NW_C;
			v_s1         <= 1'b0;
			rsp_valid_q  <= 1'b0;
			alloc_q      <= 1'b0;
			set_q        <= 1'b0;
			lo_q         <= '0;
			last_q       <= '0;
			w_s1         <= '0;
			res_page_q   <= '0;
			res_status_q <= STAT_DONE;
			rsp_page_q   <= '0;
			rsp_status_q <= STAT_DONE;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					rd_ptr_q <= rd_ptr_q + WCW'(1);
					if (rd_ptr_q == LAST_W) begin
						state_q <= S_IDLE;
						hint_q  <= NW_C;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						v_s1       <= 1'b0;
						res_page_q <= '0;
						if (req.op == OP_ALLOC) begin
							alloc_q <= 1'b1;
							if (hint_q == NW_C) begin
								res_status_q <= STAT_NO_FREE;
								state_q      <= S_DONE;
							end else begin
								rd_ptr_q <= hint_q;
								state_q  <= S_RUN;
							end
						end else begin
							alloc_q      <= 1'b0;
							res_status_q <= range_status_c;
							if (act_c && !empty_c) begin
								set_q    <= req.op == OP_RESERVE;
								lo_q     <= PCW'(lo_raw);
								last_q   <= PCW'(last_c);
								rd_ptr_q <= lo_w_c;
								state_q  <= S_RUN;
								if (req.op != OP_RESERVE && lo_w_c < hint_q) begin
									hint_q <= lo_w_c;
								end
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_RUN: begin
					v_s1 <= rd_en_c && !done_c;
					w_s1 <= rd_ptr_q;
					if (rd_en_c) begin
						rd_ptr_q <= rd_ptr_q + WCW'(1);
					end
					if (done_c) begin
						state_q <= S_DONE;
						if (alloc_q) begin
							if (has_zero_c) begin
								res_page_q   <= 32'({w_s1, fz_c}) << SH;
								res_status_q <= STAT_DONE;
								hint_q       <= w_s1;
							end else begin
								res_status_q <= STAT_NO_FREE;
								hint_q       <= NW_C;
							end
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_page_q   <= res_page_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/bpa_checker.sv @@
// Port-level assertions for the bitmap page allocator, and their bind.
// Depends on bpa_pkg and bitmap_page_allocator.
`default_nettype none

module bpa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [31:0]      rsp_page_address,
	input bpa_pkg::status_t rsp_status
);
	import bpa_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_page_address) && $stable(rsp_status))
		else $error("response payload changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_fail_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_DONE |-> rsp_page_address == '0)
		else $error("page address given with a failing status");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_page_address (rsp.page_address),
	.rsp_status       (rsp.status)
);

`default_nettype wire

@@ tb/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 100ps
// Testbench for bitmap_page_allocator: directed and random page requests are checked
// against an in-bench copy of the used-page bitmap.
// Depends on bpa_pkg, the channel interfaces in bpa_if.sv and the allocator RTL.

module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	localparam int     PAGES          = PAGE_COUNT_DEF;
	localparam int     BYTES_PER_PAGE = PAGE_BYTES_DEF;
	localparam int     MAP_WORDS      = (PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam longint MEM_TOP        = longint'(PAGES) * BYTES_PER_PAGE;
	localparam int     RANDOM_REQS    = 1650;

	typedef struct {
		op_t         op;
		logic [31:0] address;
		logic [31:0] length;
		logic [7:0]  region_type;
	} page_req_t;

	typedef struct {
		logic [31:0] page_address;
		status_t     status;
	} page_rsp_t;

	logic clk;
	logic arst_n;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	bitmap_page_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [31:0] used_map [MAP_WORDS];
	page_req_t   pending_reqs [$];
	page_rsp_t   expected_rsps [$];
	page_req_t   in_flight;
	int unsigned mismatch_count = 0;
	int unsigned req_gap;
	int unsigned rsp_gap;
	bit          req_burst = 1'b0;
	bit          rsp_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(80_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t mismatch on %s: got 0x%08h, expected 0x%08h", $time, field, got, want);
	endtask

	function automatic void mark_pages(longint lo, longint hi, bit value);
		for (longint p = lo; p < hi; p++)
			used_map[p / WORD_BITS][p % WORD_BITS] = value;
	endfunction

	function automatic page_rsp_t apply_request(page_req_t r);
		page_rsp_t res;
		longint    lo;
		longint    hi;
		int        b;
		res.page_address = '0;
		res.status       = STAT_DONE;
		case (r.op)
			OP_ALLOC: begin
				res.status = STAT_NO_FREE;
				for (int w = 0; w < MAP_WORDS; w++) begin
					if (used_map[w] != '1) begin
						b = 0;
						while (b < 31 && used_map[w][b])
							b++;
						lo = longint'(w) * WORD_BITS + b;
						if (lo < PAGES) begin
							used_map[w][b]   = 1'b1;
							res.page_address = 32'(lo * BYTES_PER_PAGE);
							res.status       = STAT_DONE;
						end
						break;
					end
				end
			end
			OP_FREE: begin
				lo = {32'b0, r.address} / BYTES_PER_PAGE;
				if (lo >= PAGES)
					res.status = STAT_RANGE;
				else
					mark_pages(lo, lo + 1, 1'b0);
			end
			OP_FREE_RANGE: begin
				if (r.region_type == REGION_USABLE) begin
					lo = {32'b0, r.address} / BYTES_PER_PAGE;
					hi = ({32'b0, r.address} + {32'b0, r.length}) / BYTES_PER_PAGE;
					if (hi > PAGES) begin
						hi         = PAGES;
						res.status = STAT_RANGE;
					end
					mark_pages(lo, hi, 1'b0);
				end
			end
			default: begin
				hi = {32'b0, r.address} / BYTES_PER_PAGE;
				if (hi > PAGES) begin
					hi         = PAGES;
					res.status = STAT_RANGE;
				end
				mark_pages(0, hi, 1'b1);
			end
		endcase
		return res;
	endfunction

	function automatic void add_req(op_t op, logic [31:0] address, logic [31:0] length,
			logic [7:0] region_type);
		page_req_t r;
		r.op          = op;
		r.address     = address;
		r.length      = length;
		r.region_type = region_type;
		pending_reqs.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.op          <= OP_ALLOC;
			req_ch.address     <= '0;
			req_ch.length      <= '0;
			req_ch.region_type <= '0;
			req_gap            <= 0;
			for (int w = 0; w < MAP_WORDS; w++)
				used_map[w] = '1;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(apply_request(in_flight));
			if (!req_ch.valid || req_ch.ready) begin
				if (req_gap != 0 || pending_reqs.size() == 0) begin
					req_ch.valid <= 1'b0;
					if (req_gap != 0)
						req_gap <= req_gap - 1;
				end else begin
					in_flight           = pending_reqs.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.op          <= in_flight.op;
					req_ch.address     <= in_flight.address;
					req_ch.length      <= in_flight.length;
					req_ch.region_type <= in_flight.region_type;
					if ($urandom_range(0, 39) == 0)
						req_burst = !req_burst;
					req_gap <= req_burst ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		page_rsp_t   want;
		int unsigned stall;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_gap      <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("response with no request waiting", rsp_ch.page_address, '0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_ch.page_address !== want.page_address)
					report_mismatch("page_address", rsp_ch.page_address, want.page_address);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
			end
			if ($urandom_range(0, 39) == 0)
				rsp_burst = !rsp_burst;
			stall = rsp_burst ? 0 : $urandom_range(0, 8);
			rsp_ch.ready <= (stall == 0);
			rsp_gap      <= stall;
		end else if (rsp_gap != 0) begin
			rsp_ch.ready <= (rsp_gap == 1);
			rsp_gap      <= rsp_gap - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		int unsigned pick;
		logic [31:0] addr;
		logic [31:0] len;
		logic [7:0]  rtype;
		logic [31:0] low_addr;

		arst_n = 1'b0;

		add_req(OP_ALLOC, '1, '1, 8'hFF);
		add_req(OP_FREE, '0, '0, '0);
		add_req(OP_ALLOC, '0, '0, '0);
		add_req(OP_FREE, '1, '0, '0);
		add_req(OP_FREE, 32'(MEM_TOP), '0, '0);
		add_req(OP_FREE, 32'(MEM_TOP - 1), '0, '0);
		add_req(OP_ALLOC, '0, '0, '0);
		add_req(OP_FREE_RANGE, '0, '1, 8'd0);
		add_req(OP_FREE_RANGE, '0, '1, 8'hFF);
		add_req(OP_FREE_RANGE, '0, '0, REGION_USABLE);
		add_req(OP_FREE_RANGE, '1, '1, REGION_USABLE);
		add_req(OP_FREE_RANGE, '0, 32'(64 * BYTES_PER_PAGE), REGION_USABLE);
		repeat (3)
			add_req(OP_ALLOC, '0, '0, '0);
		add_req(OP_RESERVE, '0, '0, '0);
		add_req(OP_RESERVE, '1, '0, '0);
		add_req(OP_ALLOC, '0, '0, '0);
		add_req(OP_FREE_RANGE, 32'(5 * BYTES_PER_PAGE + 123), 32'(40 * BYTES_PER_PAGE - 1),
			REGION_USABLE);
		add_req(OP_RESERVE, 32'(MEM_TOP), '0, '0);
		add_req(OP_RESERVE, 32'(MEM_TOP + BYTES_PER_PAGE), '0, '0);
		add_req(OP_FREE_RANGE, '0, 32'(MEM_TOP), REGION_USABLE);
		add_req(OP_RESERVE, 32'(256 * BYTES_PER_PAGE + 7), '0, '0);
		add_req(OP_ALLOC, '0, '0, '0);
		add_req(OP_FREE_RANGE, 32'(MEM_TOP - 3 * BYTES_PER_PAGE), 32'(8 * BYTES_PER_PAGE),
			REGION_USABLE);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick     = $urandom_range(0, 99);
			addr     = $urandom;
			len      = $urandom;
			rtype    = 8'($urandom);
			low_addr = $urandom_range(0, 1024 * BYTES_PER_PAGE - 1);
			if (pick < 40)
				add_req(OP_ALLOC, addr, len, rtype);
			else if (pick < 60)
				add_req(OP_FREE, low_addr, len, rtype);
			else if (pick < 70)
				add_req(OP_FREE_RANGE, low_addr, $urandom_range(0, 64 * BYTES_PER_PAGE),
					REGION_USABLE);
			else if (pick < 75)
				add_req(OP_FREE_RANGE, addr, len, (rtype == REGION_USABLE) ? 8'd0 : rtype);
			else if (pick < 80)
				add_req(OP_RESERVE, $urandom_range(0, 256 * BYTES_PER_PAGE), len, rtype);
			else if (pick < 90)
				add_req(OP_FREE, addr, len, rtype);
			else if (pick < 94)
				add_req(OP_FREE_RANGE, addr, len, REGION_USABLE);
			else if (pick < 97)
				add_req(OP_RESERVE, addr, len, rtype);
			else
				add_req(OP_FREE_RANGE, 32'(MEM_TOP) - $urandom_range(1, 64 * BYTES_PER_PAGE),
					$urandom_range(0, 64 * BYTES_PER_PAGE), REGION_USABLE);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ bitmap_page_allocator.f @@
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
tb/bitmap_page_allocator_tb.sv
